// ===== design/ipv4_prefix_trie_match_defines.svh =====
// Assertion macros for the prefix trie RTL.
`ifndef IPV4_PREFIX_TRIE_MATCH_DEFINES_SVH
`define IPV4_PREFIX_TRIE_MATCH_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IPTM_AST_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("iptm same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define IPTM_AST_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("iptm next-cycle check failed");

`endif

// ===== design/iptm_pkg.sv =====
// Shared constants, codes and control structs of the IPv4 prefix trie.
`timescale 1ns / 1ps
package iptm_pkg;

    localparam int LEVEL_TWO_TABLES_DEF   = 16;
    localparam int LEVEL_THREE_TABLES_DEF = 256;
    localparam int TAG_WIDTH_DEF          = 30;

    localparam int L1_SIZE = 4096;
    localparam int L2_SIZE = 4096;
    localparam int L3_SIZE = 256;
    localparam int PAY_W   = 30;

    localparam logic [1:0] ENT_EMPTY = 2'd0;
    localparam logic [1:0] ENT_SET   = 2'd1;
    localparam logic [1:0] ENT_TABLE = 2'd2;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_PURGE  = 2'd2;

    // Table memory access selected by the controller.
    localparam logic [3:0] A_NONE      = 4'd0;
    localparam logic [3:0] A_L1_LOOKUP = 4'd1;
    localparam logic [3:0] A_L2_LOOKUP = 4'd2;
    localparam logic [3:0] A_L3_LOOKUP = 4'd3;
    localparam logic [3:0] A_L1_RUN_RD = 4'd4;
    localparam logic [3:0] A_L1_SET    = 4'd5;
    localparam logic [3:0] A_L1_CLR    = 4'd6;
    localparam logic [3:0] A_L1_PTR    = 4'd7;
    localparam logic [3:0] A_L2_RUN_RD = 4'd8;
    localparam logic [3:0] A_L2_SET    = 4'd9;
    localparam logic [3:0] A_L2_CLR    = 4'd10;
    localparam logic [3:0] A_L2_PTR    = 4'd11;
    localparam logic [3:0] A_L3_RUN_RD = 4'd12;
    localparam logic [3:0] A_L3_SET    = 4'd13;
    localparam logic [3:0] A_L3_CLR    = 4'd14;
    localparam logic [3:0] A_F2_RD     = 4'd15;

    // Source of the pending result word.
    localparam logic [2:0] R_NONE = 3'd0;
    localparam logic [2:0] R_OK   = 3'd1;
    localparam logic [2:0] R_FULL = 3'd2;
    localparam logic [2:0] R_ROOT = 3'd3;
    localparam logic [2:0] R_L1   = 3'd4;
    localparam logic [2:0] R_L2   = 3'd5;
    localparam logic [2:0] R_L3   = 3'd6;

    typedef struct packed {
        logic       in_ready;
        logic       emit;
        logic [3:0] acc;
        logic [2:0] res;
        logic       k_clr;
        logic       k_inc;
        logic       j_clr;
        logic       j_inc;
        logic       scan_clr;
        logic       scan_inc;
        logic       root_set;
        logic       root_table;
        logic       root_empty;
        logic       free_all;
        logic       t2_from_l1;
        logic       t2_from_scan;
        logic       t3_from_l2;
        logic       t3_from_scan;
        logic       take2;
        logic       take3;
        logic       give2;
        logic       give3;
        logic       ft_load;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] kind;
        logic       p_zero;
        logic       p_le12;
        logic       p_le24;
        logic [1:0] root_code;
        logic [1:0] l1_code;
        logic       l1_ok;
        logic [1:0] l2_code;
        logic       l2_ok;
        logic       l3_set;
        logic       k_last1;
        logic       k_last2;
        logic       k_last3;
        logic       k_full12;
        logic       k_full8;
        logic       j_full;
        logic       scan_free2;
        logic       scan_free3;
        logic       scan_last2;
        logic       scan_last3;
        logic       out_free;
    } t_sts;

endpackage

// ===== design/iptm_req_if.sv =====
// Request channel: valid/ready handshake carrying one operation word.
`timescale 1ns / 1ps
interface iptm_req_if #(
    parameter int TAG_W = iptm_pkg::TAG_WIDTH_DEF
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [31:0]      address;
    logic [5:0]       prefix_len;
    logic [TAG_W-1:0] tag_in;

    modport source (output valid, output kind, output address, output prefix_len,
                    output tag_in, input ready);
    modport sink   (input valid, input kind, input address, input prefix_len,
                    input tag_in, output ready);
endinterface

// ===== design/iptm_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps
interface iptm_rsp_if #(
    parameter int TAG_W = iptm_pkg::TAG_WIDTH_DEF
) ();
    logic             valid;
    logic             ready;
    logic             status;
    logic             hit;
    logic [TAG_W-1:0] tag_out;

    modport source (output valid, output status, output hit, output tag_out,
                    input ready);
    modport sink   (input valid, input status, input hit, input tag_out,
                    output ready);
endinterface

// ===== design/ipv4_prefix_trie_match.sv =====
// IPv4 prefix lookup over a three-level 12/12/8 multibit trie.
//
// i_req carries one operation word (kind, address, prefix_len, tag_in);
// o_rsp returns exactly one result word (status, hit, tag_out) per request.
// A word moves on either channel when valid and ready are both high.
// One request is worked at a time; i_req.ready is high only when idle.
// Lookup: up to three dependent table reads; the next request is taken once
// its result has been emitted. Insert: the level-one table is swept empty
// when it is created, a new level-two or level-three table is found by a
// scan of its free map and swept empty, each entry of a covered run is read
// and, unless already set, written, and every level-two table that a short
// prefix replaces is walked and handed back with its level-three tables.
// Purge and insert of the whole space touch no table memory.
// Reset empties the trie and returns all tables to their pools at once.
// A stalled o_rsp holds its word; one further request is accepted and
// worked, and its result waits until the output register drains.
`timescale 1ns / 1ps
module ipv4_prefix_trie_match #(
    parameter int LEVEL_TWO_TABLES   = iptm_pkg::LEVEL_TWO_TABLES_DEF,
    parameter int LEVEL_THREE_TABLES = iptm_pkg::LEVEL_THREE_TABLES_DEF,
    parameter int TAG_WIDTH          = iptm_pkg::TAG_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iptm_req_if.sink   i_req,
    iptm_rsp_if.source o_rsp
);
    import iptm_pkg::*;

    `include "ipv4_prefix_trie_match_defines.svh"

    t_cmd w_cmd;
    t_sts w_sts;

    iptm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    iptm_dpath #(
        .LEVEL_TWO_TABLES   (LEVEL_TWO_TABLES),
        .LEVEL_THREE_TABLES (LEVEL_THREE_TABLES),
        .TAG_WIDTH          (TAG_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    `IPTM_AST_NEXT(a_one_in_flight, i_clk, i_rst_n,
                   i_req.valid && i_req.ready, !i_req.ready)
    `IPTM_AST_NOW(a_emit_when_free, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free)
    `IPTM_AST_NOW(a_take_free_only, i_clk, i_rst_n, w_cmd.take2 || w_cmd.take3,
                  (!w_cmd.take2 || w_sts.scan_free2) && (!w_cmd.take3 || w_sts.scan_free3))

endmodule

// ===== design/iptm_dpath.sv =====
// Datapath: trie table memories, free maps, walk counters and result registers.
`timescale 1ns / 1ps
module iptm_dpath #(
    parameter int LEVEL_TWO_TABLES   = iptm_pkg::LEVEL_TWO_TABLES_DEF,
    parameter int LEVEL_THREE_TABLES = iptm_pkg::LEVEL_THREE_TABLES_DEF,
    parameter int TAG_WIDTH          = iptm_pkg::TAG_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iptm_req_if.sink       i_req,
    iptm_rsp_if.source     o_rsp,
    input  iptm_pkg::t_cmd i_cmd,
    output iptm_pkg::t_sts o_sts
);
    import iptm_pkg::*;

    localparam int TW2 = (LEVEL_TWO_TABLES > 1) ? $clog2(LEVEL_TWO_TABLES) : 1;
    localparam int TW3 = (LEVEL_THREE_TABLES > 1) ? $clog2(LEVEL_THREE_TABLES) : 1;
    localparam int SW  = (TW2 > TW3) ? TW2 : TW3;
    localparam int AW2 = $clog2(LEVEL_TWO_TABLES * L2_SIZE);
    localparam int AW3 = $clog2(LEVEL_THREE_TABLES * L3_SIZE);
    localparam int L3W = 1 + TAG_WIDTH;

    logic [31:0] mem_l1 [L1_SIZE];
    logic [31:0] mem_l2 [LEVEL_TWO_TABLES * L2_SIZE];
    logic [L3W-1:0] mem_l3 [LEVEL_THREE_TABLES * L3_SIZE];

    logic [1:0]           r_kind;
    logic [5:0]           r_p;
    logic [31:0]          r_addr;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [1:0]           r_root_code;
    logic [TAG_WIDTH-1:0] r_root_tag;
    logic [TW2-1:0]       r_t2;
    logic [TW3-1:0]       r_t3;
    logic [TW2-1:0]       r_ft;
    logic [11:0]          r_k;
    logic [11:0]          r_j;
    logic [SW-1:0]        r_scan;
    logic [LEVEL_TWO_TABLES-1:0]   r_free2;
    logic [LEVEL_THREE_TABLES-1:0] r_free3;
    logic [31:0]          r_l1_q;
    logic [31:0]          r_l2_q;
    logic [L3W-1:0]       r_l3_q;
    logic                 r_res_status;
    logic                 r_res_hit;
    logic [TAG_WIDTH-1:0] r_res_tag;
    logic                 r_out_valid;
    logic                 r_out_status;
    logic                 r_out_hit;
    logic [TAG_WIDTH-1:0] r_out_tag;

    logic [5:0]  p_in;
    logic [11:0] idx1;
    logic [11:0] idx2;
    logic [7:0]  idx3;
    logic        l1_we, l1_re, l2_we, l2_re, l3_we, l3_re;
    logic [11:0] l1_wa, l1_ra;
    logic [31:0] l1_wd;
    logic [AW2-1:0] l2_wa, l2_ra;
    logic [31:0] l2_wd;
    logic [AW3-1:0] l3_wa, l3_ra;
    logic [L3W-1:0] l3_wd;
    logic        accept;
    logic        l2_give_ok;

    assign accept = i_req.valid && i_req.ready;
    assign p_in   = (i_req.prefix_len > 6'd32) ? 6'd32 : i_req.prefix_len;
    assign idx1   = r_addr[31:20] | r_k;
    assign idx2   = r_addr[19:8] | r_k;
    assign idx3   = r_addr[7:0] | r_k[7:0];

    always_comb begin
        l1_we = 1'b0; l1_re = 1'b0; l1_wa = idx1; l1_ra = idx1; l1_wd = '0;
        l2_we = 1'b0; l2_re = 1'b0;
        l2_wa = AW2'({r_t2, idx2}); l2_ra = AW2'({r_t2, idx2}); l2_wd = '0;
        l3_we = 1'b0; l3_re = 1'b0;
        l3_wa = AW3'({r_t3, idx3}); l3_ra = AW3'({r_t3, idx3}); l3_wd = '0;
        unique case (i_cmd.acc)
            A_NONE: ;
            A_L1_LOOKUP: begin
                l1_re = 1'b1;
                l1_ra = r_addr[31:20];
            end
            A_L2_LOOKUP: begin
                l2_re = 1'b1;
                l2_ra = AW2'({r_l1_q[31:2], r_addr[19:8]});
            end
            A_L3_LOOKUP: begin
                l3_re = 1'b1;
                l3_ra = AW3'({r_l2_q[31:2], r_addr[7:0]});
            end
            A_L1_RUN_RD: l1_re = 1'b1;
            A_L1_SET: begin
                l1_we = 1'b1;
                l1_wd = {PAY_W'(r_tag), ENT_SET};
            end
            A_L1_CLR: begin
                l1_we = 1'b1;
                l1_wa = r_k;
            end
            A_L1_PTR: begin
                l1_we = 1'b1;
                l1_wa = r_addr[31:20];
                l1_wd = {PAY_W'(r_t2), ENT_TABLE};
            end
            A_L2_RUN_RD: l2_re = 1'b1;
            A_L2_SET: begin
                l2_we = 1'b1;
                l2_wd = {PAY_W'(r_tag), ENT_SET};
            end
            A_L2_CLR: begin
                l2_we = 1'b1;
                l2_wa = AW2'({r_t2, r_k});
            end
            A_L2_PTR: begin
                l2_we = 1'b1;
                l2_wa = AW2'({r_t2, r_addr[19:8]});
                l2_wd = {PAY_W'(r_t3), ENT_TABLE};
            end
            A_L3_RUN_RD: l3_re = 1'b1;
            A_L3_SET: begin
                l3_we = 1'b1;
                l3_wd = {r_tag, 1'b1};
            end
            A_L3_CLR: begin
                l3_we = 1'b1;
                l3_wa = AW3'({r_t3, r_k[7:0]});
            end
            A_F2_RD: begin
                l2_re = 1'b1;
                l2_ra = AW2'({r_ft, r_j});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l1_we) begin
            mem_l1[l1_wa] <= l1_wd;
        end
        if (l1_re) begin
            r_l1_q <= mem_l1[l1_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (l2_we) begin
            mem_l2[l2_wa] <= l2_wd;
        end
        if (l2_re) begin
            r_l2_q <= mem_l2[l2_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (l3_we) begin
            mem_l3[l3_wa] <= l3_wd;
        end
        if (l3_re) begin
            r_l3_q <= mem_l3[l3_ra];
        end
    end

    // Item capture; an insert keeps only the network bits of its base.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.kind;
            r_p    <= p_in;
            r_tag  <= i_req.tag_in;
            r_addr <= (i_req.kind == KIND_INSERT) ?
                      (i_req.address & ~(32'hFFFF_FFFF >> p_in)) : i_req.address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 12'd1;
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + 12'd1;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + SW'(1);
        end
        if (i_cmd.t2_from_l1) begin
            r_t2 <= r_l1_q[2 +: TW2];
        end else if (i_cmd.t2_from_scan) begin
            r_t2 <= r_scan[TW2-1:0];
        end
        if (i_cmd.t3_from_l2) begin
            r_t3 <= r_l2_q[2 +: TW3];
        end else if (i_cmd.t3_from_scan) begin
            r_t3 <= r_scan[TW3-1:0];
        end
        if (i_cmd.ft_load) begin
            r_ft <= r_l1_q[2 +: TW2];
        end
    end

    assign l2_give_ok = (r_l2_q[1:0] == ENT_TABLE) && o_sts.l2_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_code <= ENT_EMPTY;
            r_free2     <= '1;
            r_free3     <= '1;
        end else begin
            if (i_cmd.root_set) begin
                r_root_code <= ENT_SET;
            end else if (i_cmd.root_table) begin
                r_root_code <= ENT_TABLE;
            end else if (i_cmd.root_empty) begin
                r_root_code <= ENT_EMPTY;
            end
            if (i_cmd.free_all) begin
                r_free2 <= '1;
                r_free3 <= '1;
            end else begin
                if (i_cmd.take2) begin
                    r_free2[r_scan[TW2-1:0]] <= 1'b0;
                end
                if (i_cmd.give2) begin
                    r_free2[r_ft] <= 1'b1;
                end
                if (i_cmd.take3) begin
                    r_free3[r_scan[TW3-1:0]] <= 1'b0;
                end
                if (i_cmd.give3 && l2_give_ok) begin
                    r_free3[r_l2_q[2 +: TW3]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_set) begin
            r_root_tag <= r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res)
            R_NONE: ;
            R_OK: begin
                r_res_status <= 1'b0; r_res_hit <= 1'b0; r_res_tag <= '0;
            end
            R_FULL: begin
                r_res_status <= 1'b1; r_res_hit <= 1'b0; r_res_tag <= '0;
            end
            R_ROOT: begin
                r_res_status <= 1'b0; r_res_hit <= 1'b1; r_res_tag <= r_root_tag;
            end
            R_L1: begin
                r_res_status <= 1'b0; r_res_hit <= 1'b1;
                r_res_tag    <= r_l1_q[2 +: TAG_WIDTH];
            end
            R_L2: begin
                r_res_status <= 1'b0; r_res_hit <= 1'b1;
                r_res_tag    <= r_l2_q[2 +: TAG_WIDTH];
            end
            R_L3: begin
                r_res_status <= 1'b0; r_res_hit <= 1'b1;
                r_res_tag    <= r_l3_q[1 +: TAG_WIDTH];
            end
            default: ;
        endcase
    end

    // Output register holds its word until taken; a new word may load as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_hit    <= r_res_hit;
            r_out_tag    <= r_res_tag;
        end
    end

    assign i_req.ready   = i_cmd.in_ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_out_status;
    assign o_rsp.hit     = r_out_hit;
    assign o_rsp.tag_out = r_out_tag;

    always_comb begin
        o_sts.in_valid   = i_req.valid;
        o_sts.kind       = r_kind;
        o_sts.p_zero     = (r_p == 6'd0);
        o_sts.p_le12     = (r_p <= 6'd12);
        o_sts.p_le24     = (r_p <= 6'd24);
        o_sts.root_code  = r_root_code;
        o_sts.l1_code    = r_l1_q[1:0];
        o_sts.l1_ok      = (r_l1_q[31:2] < PAY_W'(LEVEL_TWO_TABLES));
        o_sts.l2_code    = r_l2_q[1:0];
        o_sts.l2_ok      = (r_l2_q[31:2] < PAY_W'(LEVEL_THREE_TABLES));
        o_sts.l3_set     = r_l3_q[0];
        o_sts.k_last1    = (r_k == (12'hFFF >> r_p));
        o_sts.k_last2    = (r_k == (12'hFFF >> (r_p - 6'd12)));
        o_sts.k_last3    = (r_k[7:0] == (8'hFF >> (r_p - 6'd24)));
        o_sts.k_full12   = (r_k == 12'hFFF);
        o_sts.k_full8    = (r_k[7:0] == 8'hFF);
        o_sts.j_full     = (r_j == 12'hFFF);
        o_sts.scan_free2 = r_free2[r_scan[TW2-1:0]];
        o_sts.scan_free3 = r_free3[r_scan[TW3-1:0]];
        o_sts.scan_last2 = (r_scan == SW'(LEVEL_TWO_TABLES - 1));
        o_sts.scan_last3 = (r_scan == SW'(LEVEL_THREE_TABLES - 1));
        o_sts.out_free   = !r_out_valid || o_rsp.ready;
    end

endmodule

// ===== design/iptm_ctrl.sv =====
// Controller: sequences lookups, inserts, table clears and table frees.
`timescale 1ns / 1ps
module iptm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  iptm_pkg::t_sts i_sts,
    output iptm_pkg::t_cmd o_cmd
);
    import iptm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_LK1    = 5'd2;
    localparam logic [4:0] S_LK2    = 5'd3;
    localparam logic [4:0] S_LK3    = 5'd4;
    localparam logic [4:0] S_CLR1   = 5'd5;
    localparam logic [4:0] S_I1     = 5'd6;
    localparam logic [4:0] S_R1_RD  = 5'd7;
    localparam logic [4:0] S_R1_CK  = 5'd8;
    localparam logic [4:0] S_F2_RD  = 5'd9;
    localparam logic [4:0] S_F2_CK  = 5'd10;
    localparam logic [4:0] S_I1_CK  = 5'd11;
    localparam logic [4:0] S_TAKE2  = 5'd12;
    localparam logic [4:0] S_CLR2   = 5'd13;
    localparam logic [4:0] S_W1PTR  = 5'd14;
    localparam logic [4:0] S_I2     = 5'd15;
    localparam logic [4:0] S_R2_RD  = 5'd16;
    localparam logic [4:0] S_R2_CK  = 5'd17;
    localparam logic [4:0] S_I2_CK  = 5'd18;
    localparam logic [4:0] S_TAKE3  = 5'd19;
    localparam logic [4:0] S_CLR3   = 5'd20;
    localparam logic [4:0] S_W2PTR  = 5'd21;
    localparam logic [4:0] S_R3_RD  = 5'd22;
    localparam logic [4:0] S_R3_CK  = 5'd23;
    localparam logic [4:0] S_DONE   = 5'd24;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                o_cmd.res = R_OK;
                unique case (i_sts.kind)
                    KIND_LOOKUP: begin
                        if (i_sts.root_code == ENT_SET) begin
                            o_cmd.res = R_ROOT;
                        end else if (i_sts.root_code == ENT_TABLE) begin
                            o_cmd.res = R_NONE;
                            o_cmd.acc = A_L1_LOOKUP;
                            n_state   = S_LK1;
                        end
                    end
                    KIND_INSERT: begin
                        if (i_sts.p_zero) begin
                            if (i_sts.root_code != ENT_SET) begin
                                o_cmd.root_set = 1'b1;
                                o_cmd.free_all = 1'b1;
                            end
                        end else if (i_sts.root_code != ENT_SET) begin
                            o_cmd.res   = R_NONE;
                            o_cmd.k_clr = 1'b1;
                            n_state = (i_sts.root_code == ENT_TABLE) ? S_I1 : S_CLR1;
                        end
                    end
                    KIND_PURGE: begin
                        o_cmd.root_empty = 1'b1;
                        o_cmd.free_all   = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_LK1: begin
                n_state = S_DONE;
                if (i_sts.l1_code == ENT_SET) begin
                    o_cmd.res = R_L1;
                end else if (i_sts.l1_code == ENT_TABLE && i_sts.l1_ok) begin
                    o_cmd.acc = A_L2_LOOKUP;
                    n_state   = S_LK2;
                end else begin
                    o_cmd.res = R_OK;
                end
            end
            S_LK2: begin
                n_state = S_DONE;
                if (i_sts.l2_code == ENT_SET) begin
                    o_cmd.res = R_L2;
                end else if (i_sts.l2_code == ENT_TABLE && i_sts.l2_ok) begin
                    o_cmd.acc = A_L3_LOOKUP;
                    n_state   = S_LK3;
                end else begin
                    o_cmd.res = R_OK;
                end
            end
            S_LK3: begin
                n_state   = S_DONE;
                o_cmd.res = i_sts.l3_set ? R_L3 : R_OK;
            end
            // A fresh level-one table is swept empty one entry a cycle.
            S_CLR1: begin
                o_cmd.acc = A_L1_CLR;
                if (i_sts.k_full12) begin
                    o_cmd.root_table = 1'b1;
                    o_cmd.k_clr      = 1'b1;
                    n_state          = S_I1;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_I1: begin
                if (i_sts.p_le12) begin
                    n_state = S_R1_RD;
                end else begin
                    o_cmd.acc = A_L1_RUN_RD;
                    n_state   = S_I1_CK;
                end
            end
            S_R1_RD: begin
                o_cmd.acc = A_L1_RUN_RD;
                n_state   = S_R1_CK;
            end
            S_R1_CK: begin
                if (i_sts.l1_code != ENT_SET) begin
                    o_cmd.acc = A_L1_SET;
                end
                if (i_sts.l1_code == ENT_TABLE && i_sts.l1_ok) begin
                    o_cmd.ft_load = 1'b1;
                    o_cmd.j_clr   = 1'b1;
                    n_state       = S_F2_RD;
                end else if (i_sts.k_last1) begin
                    o_cmd.res = R_OK;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_R1_RD;
                end
            end
            // Walk a replaced level-two table and hand back it and its level-three tables.
            S_F2_RD: begin
                o_cmd.acc = A_F2_RD;
                n_state   = S_F2_CK;
            end
            S_F2_CK: begin
                o_cmd.give3 = 1'b1;
                if (!i_sts.j_full) begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_F2_RD;
                end else begin
                    o_cmd.give2 = 1'b1;
                    if (i_sts.k_last1) begin
                        o_cmd.res = R_OK;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_R1_RD;
                    end
                end
            end
            S_I1_CK: begin
                if (i_sts.l1_code == ENT_SET) begin
                    o_cmd.res = R_OK;
                    n_state   = S_DONE;
                end else if (i_sts.l1_code == ENT_TABLE && i_sts.l1_ok) begin
                    o_cmd.t2_from_l1 = 1'b1;
                    n_state          = S_I2;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_TAKE2;
                end
            end
            S_TAKE2: begin
                if (i_sts.scan_free2) begin
                    o_cmd.take2        = 1'b1;
                    o_cmd.t2_from_scan = 1'b1;
                    o_cmd.k_clr        = 1'b1;
                    n_state            = S_CLR2;
                end else if (i_sts.scan_last2) begin
                    o_cmd.res = R_FULL;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_CLR2: begin
                o_cmd.acc = A_L2_CLR;
                if (i_sts.k_full12) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_W1PTR;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_W1PTR: begin
                o_cmd.acc = A_L1_PTR;
                n_state   = S_I2;
            end
            S_I2: begin
                if (i_sts.p_le24) begin
                    n_state = S_R2_RD;
                end else begin
                    o_cmd.acc = A_L2_RUN_RD;
                    n_state   = S_I2_CK;
                end
            end
            S_R2_RD: begin
                o_cmd.acc = A_L2_RUN_RD;
                n_state   = S_R2_CK;
            end
            S_R2_CK: begin
                if (i_sts.l2_code != ENT_SET) begin
                    o_cmd.acc   = A_L2_SET;
                    o_cmd.give3 = 1'b1;
                end
                if (i_sts.k_last2) begin
                    o_cmd.res = R_OK;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_R2_RD;
                end
            end
            S_I2_CK: begin
                if (i_sts.l2_code == ENT_SET) begin
                    o_cmd.res = R_OK;
                    n_state   = S_DONE;
                end else if (i_sts.l2_code == ENT_TABLE && i_sts.l2_ok) begin
                    o_cmd.t3_from_l2 = 1'b1;
                    n_state          = S_R3_RD;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_TAKE3;
                end
            end
            S_TAKE3: begin
                if (i_sts.scan_free3) begin
                    o_cmd.take3        = 1'b1;
                    o_cmd.t3_from_scan = 1'b1;
                    o_cmd.k_clr        = 1'b1;
                    n_state            = S_CLR3;
                end else if (i_sts.scan_last3) begin
                    o_cmd.res = R_FULL;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_CLR3: begin
                o_cmd.acc = A_L3_CLR;
                if (i_sts.k_full8) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_W2PTR;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_W2PTR: begin
                o_cmd.acc = A_L2_PTR;
                n_state   = S_R3_RD;
            end
            S_R3_RD: begin
                o_cmd.acc = A_L3_RUN_RD;
                n_state   = S_R3_CK;
            end
            S_R3_CK: begin
                if (!i_sts.l3_set) begin
                    o_cmd.acc = A_L3_SET;
                end
                if (i_sts.k_last3) begin
                    o_cmd.res = R_OK;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_R3_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
